/* src/wavhp_pkg.sv */
// wavhp_pkg: shared types and constants for the wave header parser
// used by wavhp_parser and wav_header_parser; no dependencies
package wavhp_pkg;

  // bytes of a file that may be spent on the header
  localparam int unsigned HEADER_WINDOW = 1024;
  // byte position width, wide enough to hold the window itself
  localparam int unsigned POS_W = $clog2(HEADER_WINDOW + 1);
  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned RESULT_W = 176;

  // chunk tags as they sit in the four-byte shift field
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_LEN_PCM = 32'h0000_0010;
  localparam logic [15:0] FORMAT_PCM = 16'd1;
  localparam logic [15:0] BITS_16 = 16'd16;
  // first byte after the fmt chunk, and after fact chunk header
  localparam logic [POS_W-1:0] DATA_TAG_DEFAULT = POS_W'(36);
  localparam int unsigned FACT_END = 46;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_RIFF    = 4'd1,
    ST_WAVE    = 4'd2,
    ST_FMT     = 4'd3,
    ST_NOT_PCM = 4'd4,
    ST_NOT_16  = 4'd5,
    ST_CBSIZE  = 4'd6,
    ST_FACT    = 4'd7,
    ST_DATA    = 4'd8,
    ST_LONG    = 4'd9
  } wavhp_status_t;

  // result item, first member in the top bits
  typedef struct packed {
    logic                pad;
    logic [OFFSET_W-1:0] data_offset;
    logic [31:0]         data_size;
    logic [15:0]         block_align;
    logic [31:0]         byte_rate;
    logic [31:0]         sample_rate;
    logic [15:0]         channel_count;
    logic [31:0]         chunk_size;
    wavhp_status_t       status;
  } wavhp_result_t;

  // one byte handed to the parse stage
  typedef struct packed {
    logic       en;
    logic       start;
    logic [7:0] data_byte;
  } wavhp_step_t;

endpackage

/* src/wavhp_parser.sv */
// wavhp_parser: per-byte header state and field checks, one byte a cycle while step.en is high
// depends on wavhp_pkg
module wavhp_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  wavhp_pkg::wavhp_step_t  step,
  output logic                    emit,
  output wavhp_pkg::wavhp_result_t result
);

  localparam int unsigned PW = wavhp_pkg::POS_W;

  logic [PW-1:0] pos, pos_next, pos_e;
  logic [31:0]   shift, shift_next, shift_e;
  logic          fact, fact_next, fact_e;
  logic [PW-1:0] dtp, dtp_next, dtp_e;
  logic [31:0]   csize, csize_next, csize_e;
  logic [15:0]   chans, chans_next, chans_e;
  logic [15:0]   balign, balign_next, balign_e;
  logic [31:0]   srate, srate_next, srate_e;
  logic [31:0]   brate, brate_next, brate_e;
  logic          done, done_next, done_e;

  logic [31:0]   acc;
  logic [15:0]   hi;
  logic [PW:0]   pos_w, tag_end, size_end;
  wavhp_pkg::wavhp_status_t st;
  logic [31:0]   dsize;
  logic [PW-1:0] doff;
  logic          ok;

  assign acc      = {step.data_byte, shift_e[31:8]};
  assign hi       = acc[31:16];
  assign pos_w    = {1'b0, pos_e};
  assign tag_end  = {1'b0, dtp_e} + (PW+1)'(3);
  assign size_end = {1'b0, dtp_e} + (PW+1)'(7);

  // restart values, then the checks for the byte at this position
  always_comb begin
    pos_e   = step.start ? '0 : pos;
    shift_e = step.start ? '0 : shift;
    fact_e  = step.start ? 1'b0 : fact;
    dtp_e   = step.start ? wavhp_pkg::DATA_TAG_DEFAULT : dtp;
    csize_e = step.start ? '0 : csize;
    chans_e = step.start ? '0 : chans;
    balign_e = step.start ? '0 : balign;
    srate_e = step.start ? '0 : srate;
    brate_e = step.start ? '0 : brate;
    done_e  = step.start ? 1'b0 : done;

    pos_next = pos;  shift_next = shift;  fact_next = fact;  dtp_next = dtp;
    csize_next = csize;  chans_next = chans;  balign_next = balign;
    srate_next = srate;  brate_next = brate;  done_next = done;
    emit = 1'b0;
    st = wavhp_pkg::ST_OK;
    dsize = '0;
    doff = '0;

    if (step.en) begin
      pos_next = pos_e;  shift_next = shift_e;  fact_next = fact_e;  dtp_next = dtp_e;
      csize_next = csize_e;  chans_next = chans_e;  balign_next = balign_e;
      srate_next = srate_e;  brate_next = brate_e;  done_next = done_e;
      if (!done_e) begin
        if (pos_w >= (PW+1)'(wavhp_pkg::HEADER_WINDOW)) begin
          emit = 1'b1;
          st = wavhp_pkg::ST_LONG;
        end else begin
          shift_next = acc;
          priority if (pos_e == PW'(3)) begin
            if (acc != wavhp_pkg::TAG_RIFF) begin emit = 1'b1; st = wavhp_pkg::ST_RIFF; end
          end else if (pos_e == PW'(7)) begin
            csize_next = acc;
          end else if (pos_e == PW'(11)) begin
            if (acc != wavhp_pkg::TAG_WAVE) begin emit = 1'b1; st = wavhp_pkg::ST_WAVE; end
          end else if (pos_e == PW'(15)) begin
            if (acc != wavhp_pkg::TAG_FMT) begin emit = 1'b1; st = wavhp_pkg::ST_FMT; end
          end else if (pos_e == PW'(19)) begin
            fact_next = (acc != wavhp_pkg::FMT_LEN_PCM);
          end else if (pos_e == PW'(21)) begin
            if (hi != wavhp_pkg::FORMAT_PCM) begin
              emit = 1'b1; st = wavhp_pkg::ST_NOT_PCM;
            end
          end else if (pos_e == PW'(23)) begin
            chans_next = hi;
          end else if (pos_e == PW'(27)) begin
            srate_next = acc;
          end else if (pos_e == PW'(31)) begin
            brate_next = acc;
          end else if (pos_e == PW'(33)) begin
            balign_next = hi;
          end else if (pos_e == PW'(35)) begin
            if (hi != wavhp_pkg::BITS_16) begin emit = 1'b1; st = wavhp_pkg::ST_NOT_16; end
          end else if (fact_e && pos_e <= PW'(45)) begin
            // cbSize, fact tag and fact size
            if (pos_e == PW'(37)) begin
              if (hi != 16'd0) begin emit = 1'b1; st = wavhp_pkg::ST_CBSIZE; end
            end else if (pos_e == PW'(41)) begin
              if (acc != wavhp_pkg::TAG_FACT) begin emit = 1'b1; st = wavhp_pkg::ST_FACT; end
            end else if (pos_e == PW'(45)) begin
              if (acc > 32'(wavhp_pkg::HEADER_WINDOW - wavhp_pkg::FACT_END)) begin
                dtp_next = PW'(wavhp_pkg::HEADER_WINDOW);
              end else begin
                dtp_next = PW'(wavhp_pkg::FACT_END) + acc[PW-1:0];
              end
            end
          end else if (pos_e > PW'(35)) begin
            // data tag and data size
            if (pos_w == tag_end) begin
              if (acc != wavhp_pkg::TAG_DATA) begin emit = 1'b1; st = wavhp_pkg::ST_DATA; end
            end else if (pos_w == size_end) begin
              emit = 1'b1;
              st = wavhp_pkg::ST_OK;
              dsize = acc;
              doff = dtp_e + PW'(8);
            end
          end else begin
            // bytes inside a fixed field carry no check
          end
          if (!emit) pos_next = pos_e + PW'(1);
        end
        if (emit) done_next = 1'b1;
      end
    end
  end

  // result fields, format fields only on success
  assign ok = (st == wavhp_pkg::ST_OK);
  always_comb begin
    result.pad           = 1'b0;
    result.status        = st;
    result.chunk_size    = csize_e;
    result.channel_count = ok ? chans_e : '0;
    result.sample_rate   = ok ? srate_e : '0;
    result.byte_rate     = ok ? brate_e : '0;
    result.block_align   = ok ? balign_e : '0;
    result.data_size     = ok ? dsize : '0;
    result.data_offset   = ok ? wavhp_pkg::OFFSET_W'(doff) : '0;
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      shift <= '0;
      fact <= 1'b0;
      dtp <= wavhp_pkg::DATA_TAG_DEFAULT;
      csize <= '0;
      chans <= '0;
      balign <= '0;
      srate <= '0;
      brate <= '0;
      done <= 1'b1;
    end else begin
      pos <= pos_next;
      shift <= shift_next;
      fact <= fact_next;
      dtp <= dtp_next;
      csize <= csize_next;
      chans <= chans_next;
      balign <= balign_next;
      srate <= srate_next;
      brate <= brate_next;
      done <= done_next;
    end
  end

  // position never runs past the window
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(wavhp_pkg::HEADER_WINDOW))
    else $error("byte position beyond header window");

  // data tag position stays between its default and the window
  a_dtp_range: assert property (@(posedge clk) disable iff (rst)
    dtp >= wavhp_pkg::DATA_TAG_DEFAULT && dtp <= PW'(wavhp_pkg::HEADER_WINDOW))
    else $error("data tag position out of range");

  // a result ends the file until the next start
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    step.en && emit |=> done)
    else $error("parser still active after result");

  // a successful result places the sample data after the fmt chunk
  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    emit && st == wavhp_pkg::ST_OK |-> doff >= PW'(44))
    else $error("data offset too small for a valid header");

endmodule

/* src/wav_header_parser.sv */
// wav_header_parser: top level, input register, parse stage and result register
// depends on wavhp_pkg and wavhp_parser
//
// Streams a file one byte per item and parses its RIFF/WAVE PCM header. A byte
// with s_tuser high is byte 0 of a new file; bytes seen after a result, or
// before any start, are dropped. At most one result item comes per file: at
// the last byte of the first field that fails, at the last byte of the data
// chunk size, or at the first byte past the header window. One byte is taken
// every cycle unless the input side stalls; a byte passes from the input
// register through the parse logic into the result register, which offers
// the result. The input side stalls only while a byte waits in the input
// register and the result register is full and not being taken.
module wav_header_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // data_byte
  input  logic                         s_tuser,   // start_flag
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // status[3:0], chunk_size[35:4], channel_count[51:36], sample_rate[83:52],
  // byte_rate[115:84], block_align[131:116], data_size[163:132],
  // data_offset[174:164], zero[175]
  output logic [wavhp_pkg::RESULT_W-1:0] m_tdata
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;
  logic       emit;
  wavhp_pkg::wavhp_step_t   step;
  wavhp_pkg::wavhp_result_t result;
  wavhp_pkg::wavhp_result_t out_data;

  // the parse stage moves when the result register can take a result
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  assign step.en        = in_valid && advance;
  assign step.start     = in_start;
  assign step.data_byte = in_byte;

  wavhp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .emit   (emit),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step.en && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step.en && emit) begin
      out_data <= result;
    end
  end

  assign m_tdata = out_data;

  // a failed header never reports format fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_data.status != wavhp_pkg::ST_OK |->
      out_data.sample_rate == '0 && out_data.data_offset == '0)
    else $error("error result carries format fields");

  // a byte held in the input register is not lost while the output stalls
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled byte dropped");

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for wav_header_parser, directed files then random ones
// depends on wavhp_pkg and wav_header_parser; predicts each header result on its own
module testbench;

  localparam int unsigned WIN = wavhp_pkg::HEADER_WINDOW;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [wavhp_pkg::RESULT_W-1:0] m_tdata;

  wav_header_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // header content before it is laid out as bytes
  typedef struct {
    logic [31:0] riff_tag, riff_size, wave_tag, fmt_tag, fmt_len;
    logic [15:0] fmt_code, channels;
    logic [31:0] sample_rate, byte_rate;
    logic [15:0] align, bits, cb_size;
    logic [31:0] fact_tag, fact_size, data_tag, data_size;
  } wav_fields_t;

  // parser state as the header is walked
  logic [wavhp_pkg::POS_W-1:0] pos;
  logic [31:0]      shift_word;
  logic             fact_seen;
  logic [wavhp_pkg::POS_W-1:0] data_at;
  logic [31:0]      cap_riff_size;
  logic [15:0]      cap_channels, cap_align;
  logic [31:0]      cap_rate, cap_brate;
  logic             parse_idle = 1'b1;

  wavhp_pkg::wavhp_result_t expected_headers[$];
  logic [7:0]    file_bytes[$];
  int            error_count = 0;
  int            bytes_sent = 0;
  bit            full_rate = 1'b0;
  int            hold_req = 0;
  wavhp_pkg::wavhp_result_t seen, want;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void restart_parse();
    pos = '0;
    shift_word = '0;
    fact_seen = 1'b0;
    data_at = wavhp_pkg::DATA_TAG_DEFAULT;
    cap_riff_size = '0;
    cap_channels = '0;
    cap_align = '0;
    cap_rate = '0;
    cap_brate = '0;
  endfunction

  // one accepted byte; returns 1 with the header result when the byte ends the header
  function automatic bit parse_byte(input logic [7:0] b, input logic sof,
                                    output wavhp_pkg::wavhp_result_t r);
    logic [wavhp_pkg::POS_W-1:0] p;
    logic [31:0]      acc;
    logic [15:0]      hi;
    logic [32:0]      tag_sum;
    bit               hit;
    wavhp_pkg::wavhp_status_t code;
    logic [31:0]      dsize;
    logic [wavhp_pkg::POS_W-1:0] off;
    r = '0;
    hit = 1'b0;
    code = wavhp_pkg::ST_OK;
    dsize = '0;
    off = '0;
    if (sof) begin
      restart_parse();
      parse_idle = 1'b0;
    end
    if (parse_idle) return 1'b0;
    p = pos;
    if (p >= WIN) begin
      hit = 1'b1;
      code = wavhp_pkg::ST_LONG;
    end else begin
      shift_word = {b, shift_word[31:8]};
      acc = shift_word;
      hi = acc[31:16];
      // checks fire on the last byte of each fixed field
      if (p == 3) begin
        if (acc != wavhp_pkg::TAG_RIFF) begin hit = 1'b1; code = wavhp_pkg::ST_RIFF; end
      end else if (p == 7) begin
        cap_riff_size = acc;
      end else if (p == 11) begin
        if (acc != wavhp_pkg::TAG_WAVE) begin hit = 1'b1; code = wavhp_pkg::ST_WAVE; end
      end else if (p == 15) begin
        if (acc != wavhp_pkg::TAG_FMT) begin hit = 1'b1; code = wavhp_pkg::ST_FMT; end
      end else if (p == 19) begin
        fact_seen = (acc != wavhp_pkg::FMT_LEN_PCM);
      end else if (p == 21) begin
        if (hi != wavhp_pkg::FORMAT_PCM) begin hit = 1'b1; code = wavhp_pkg::ST_NOT_PCM; end
      end else if (p == 23) begin
        cap_channels = hi;
      end else if (p == 27) begin
        cap_rate = acc;
      end else if (p == 31) begin
        cap_brate = acc;
      end else if (p == 33) begin
        cap_align = hi;
      end else if (p == 35) begin
        if (hi != wavhp_pkg::BITS_16) begin hit = 1'b1; code = wavhp_pkg::ST_NOT_16; end
      end else if (fact_seen && p <= 45) begin
        // cbSize, fact tag, fact size
        if (p == 37) begin
          if (hi != 16'h0000) begin hit = 1'b1; code = wavhp_pkg::ST_CBSIZE; end
        end else if (p == 41) begin
          if (acc != wavhp_pkg::TAG_FACT) begin hit = 1'b1; code = wavhp_pkg::ST_FACT; end
        end else if (p == 45) begin
          tag_sum = 33'(wavhp_pkg::FACT_END) + 33'(acc);
          data_at = (tag_sum > 33'(WIN)) ? wavhp_pkg::POS_W'(WIN)
                                         : tag_sum[wavhp_pkg::POS_W-1:0];
        end
      end else if (p > 35) begin
        if (p == data_at + 3) begin
          if (acc != wavhp_pkg::TAG_DATA) begin hit = 1'b1; code = wavhp_pkg::ST_DATA; end
        end else if (p == data_at + 7) begin
          hit = 1'b1;
          code = wavhp_pkg::ST_OK;
          dsize = acc;
          off = data_at + wavhp_pkg::POS_W'(8);
        end
      end
    end
    if (!hit) begin
      pos = p + 1'b1;
      return 1'b0;
    end
    parse_idle = 1'b1;
    r.status = code;
    r.chunk_size = cap_riff_size;
    if (code == wavhp_pkg::ST_OK) begin
      r.channel_count = cap_channels;
      r.sample_rate = cap_rate;
      r.byte_rate = cap_brate;
      r.block_align = cap_align;
      r.data_size = dsize;
      r.data_offset = off[wavhp_pkg::OFFSET_W-1:0];
    end
    return 1'b1;
  endfunction

  // drive one item, wait for its handshake, then predict
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int            gap;
    wavhp_pkg::wavhp_result_t r;
    gap = full_rate ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= sof;
    do @(posedge clk); while (s_tready !== 1'b1);
    bytes_sent++;
    if (parse_byte(b, sof, r)) expected_headers.push_back(r);
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == 0);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  // lay out a header as file bytes; fact padding capped past the window
  task automatic build_file(input wav_fields_t f);
    int pad;
    file_bytes.delete();
    put_le(f.riff_tag, 4);
    put_le(f.riff_size, 4);
    put_le(f.wave_tag, 4);
    put_le(f.fmt_tag, 4);
    put_le(f.fmt_len, 4);
    put_le(32'(f.fmt_code), 2);
    put_le(32'(f.channels), 2);
    put_le(f.sample_rate, 4);
    put_le(f.byte_rate, 4);
    put_le(32'(f.align), 2);
    put_le(32'(f.bits), 2);
    if (f.fmt_len != wavhp_pkg::FMT_LEN_PCM) begin
      put_le(32'(f.cb_size), 2);
      put_le(f.fact_tag, 4);
      put_le(f.fact_size, 4);
      pad = (f.fact_size > 1000) ? 1000 : int'(f.fact_size);
      repeat (pad) file_bytes.push_back(8'($urandom));
    end
    put_le(f.data_tag, 4);
    put_le(f.data_size, 4);
  endtask

  // well-formed header with random content
  function automatic wav_fields_t random_fields();
    wav_fields_t f;
    f.riff_tag = wavhp_pkg::TAG_RIFF;
    f.riff_size = $urandom;
    f.wave_tag = wavhp_pkg::TAG_WAVE;
    f.fmt_tag = wavhp_pkg::TAG_FMT;
    if ($urandom_range(0, 2) == 0) f.fmt_len = $urandom_range(0, 1) ? 32'd18 : $urandom;
    else f.fmt_len = wavhp_pkg::FMT_LEN_PCM;
    f.fmt_code = wavhp_pkg::FORMAT_PCM;
    f.channels = 16'($urandom);
    f.sample_rate = $urandom;
    f.byte_rate = $urandom;
    f.align = 16'($urandom);
    f.bits = wavhp_pkg::BITS_16;
    f.cb_size = '0;
    f.fact_tag = wavhp_pkg::TAG_FACT;
    f.fact_size = $urandom_range(0, 12);
    f.data_tag = wavhp_pkg::TAG_DATA;
    f.data_size = $urandom;
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    error_count++;
    $display("%0t: mismatch %s: got %h, expected %h", $realtime, what, got, exp_val);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      seen = m_tdata;
      if (expected_headers.size() == 0) begin
        report_mismatch("status of unexpected result", 32'(seen.status), '0);
      end else begin
        want = expected_headers.pop_front();
        compare_field("status", 32'(seen.status), 32'(want.status));
        compare_field("chunk_size", seen.chunk_size, want.chunk_size);
        compare_field("channel_count", 32'(seen.channel_count), 32'(want.channel_count));
        compare_field("sample_rate", seen.sample_rate, want.sample_rate);
        compare_field("byte_rate", seen.byte_rate, want.byte_rate);
        compare_field("block_align", 32'(seen.block_align), 32'(want.block_align));
        compare_field("data_size", seen.data_size, want.data_size);
        compare_field("data_offset", 32'(seen.data_offset), 32'(want.data_offset));
        compare_field("pad bit", 32'(seen.pad), 32'(want.pad));
      end
    end
  end

  // result side: random stall per item, or one long hold-off when asked
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = full_rate ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  // stray bytes, restarts mid header, bytes after a result
  task automatic test_idle_and_restart();
    wav_fields_t f;
    int          i;
    repeat (6) send_byte(8'($urandom), 1'b0);
    f = random_fields();
    build_file(f);
    for (i = 0; i < 20; i++) send_byte(file_bytes[i], i == 0);
    f = random_fields();
    f.fmt_len = wavhp_pkg::FMT_LEN_PCM;
    build_file(f);
    for (i = 0; i < 38; i++) send_byte(file_bytes[i], i == 0);
    f = random_fields();
    build_file(f);
    send_file();
    repeat (5) send_byte(8'($urandom), 1'b0);
  endtask

  // all-ones and all-zero field values, both fmt lengths
  task automatic test_field_extremes();
    wav_fields_t f;
    f = random_fields();
    f.fmt_len = wavhp_pkg::FMT_LEN_PCM;
    f.riff_size = '1;
    f.channels = '1;
    f.sample_rate = '1;
    f.byte_rate = '1;
    f.align = '1;
    f.data_size = '1;
    build_file(f);
    send_file();
    f.riff_size = '0;
    f.channels = '0;
    f.sample_rate = '0;
    f.byte_rate = '0;
    f.align = '0;
    f.data_size = '0;
    build_file(f);
    send_file();
    f.fmt_len = '1;
    f.fact_size = '0;
    build_file(f);
    send_file();
    f = random_fields();
    f.fmt_len = '0;
    f.fact_size = 32'd1;
    build_file(f);
    send_file();
  endtask

  // one file per error status from ST_RIFF to ST_DATA, each with its own field broken
  task automatic test_status_codes();
    wav_fields_t   f;
    wavhp_pkg::wavhp_status_t code;
    int            c;
    int            k;
    for (c = wavhp_pkg::ST_RIFF; c <= wavhp_pkg::ST_DATA; c++) begin
      code = wavhp_pkg::wavhp_status_t'(c);
      f = random_fields();
      k = $urandom_range(0, 15);
      case (code)
        wavhp_pkg::ST_RIFF: f.riff_tag[k] = ~f.riff_tag[k];
        wavhp_pkg::ST_WAVE: f.wave_tag[k + 16] = ~f.wave_tag[k + 16];
        wavhp_pkg::ST_FMT: f.fmt_tag[k] = ~f.fmt_tag[k];
        wavhp_pkg::ST_NOT_PCM: f.fmt_code[k] = ~f.fmt_code[k];
        wavhp_pkg::ST_NOT_16: f.bits[k] = ~f.bits[k];
        wavhp_pkg::ST_CBSIZE: begin
          f.fmt_len = 32'd18;
          f.cb_size = 16'h0001 << k;
        end
        wavhp_pkg::ST_FACT: begin
          f.fmt_len = 32'd18;
          f.fact_tag[k] = ~f.fact_tag[k];
        end
        wavhp_pkg::ST_DATA: f.data_tag[k] = ~f.data_tag[k];
        default: ;
      endcase
      build_file(f);
      send_file();
    end
  endtask

  // saturated fact size puts the data tag past the window, header runs too long
  task automatic test_window_edges();
    wav_fields_t f;
    f = random_fields();
    f.fmt_len = 32'd18;
    f.fact_size = '1;
    build_file(f);
    send_file();
  endtask

  // receiver holds off while short failing files keep coming
  task automatic test_back_pressure();
    wav_fields_t f;
    full_rate = 1'b1;
    hold_req = 300;
    repeat (4) begin
      f = random_fields();
      f.riff_tag[$urandom_range(0, 31)] ^= 1'b1;
      build_file(f);
      send_file();
    end
    full_rate = 1'b0;
  endtask

  // mostly well-formed files, some with a flipped bit, cut short or trailed by noise
  task automatic test_random_files();
    wav_fields_t f;
    int          first_byte;
    int          kind;
    int          idx;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < 250) begin
      full_rate = ($urandom_range(0, 4) == 0);
      f = random_fields();
      build_file(f);
      kind = $urandom_range(0, 9);
      if (kind == 6 || kind == 7) begin
        idx = $urandom_range(0, file_bytes.size() - 1);
        file_bytes[idx][$urandom_range(0, 7)] ^= 1'b1;
      end else if (kind == 8) begin
        idx = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > idx) void'(file_bytes.pop_back());
      end
      send_file();
      if (kind == 9) repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
    end
    full_rate = 1'b0;
  endtask

  // main sequence
  initial begin
    restart_parse();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_and_restart();
    test_field_extremes();
    test_status_codes();
    test_window_edges();
    test_back_pressure();
    test_random_files();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("wav_header_parser verification clean");
    end else begin
      $display("wav_header_parser verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("wav_header_parser verification failed");
    $finish;
  end

endmodule

/* wav_header_parser.f */
src/wavhp_pkg.sv
src/wavhp_parser.sv
src/wav_header_parser.sv
tb/testbench.sv
